// ----- hw/rtl/hbsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hbsa_pkg: shared types and codes for the hierarchical bitmap slot allocator
// Sequencer states, transaction action codes and result status codes.
// ----------------------------------------------------------------------------
package hbsa_pkg;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOM = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_M3,
    S_M2,
    S_MR,
    S_PK2,
    S_PK3,
    S_FW,
    S_OUT
  } state_t;

endpackage

// ----- hw/rtl/hbsa_ram.sv -----
// ----------------------------------------------------------------------------
// hbsa_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module hbsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/hbsa_find.sv -----
// ----------------------------------------------------------------------------
// hbsa_find: lowest clear bit search
// Returns the position of the lowest clear bit of a bitmap word and
// whether any clear bit exists. Shared by every tree level.
// ----------------------------------------------------------------------------
module hbsa_find #(
  parameter int FANOUT_LOG2 = 4
) (
  input  logic [(1<<FANOUT_LOG2)-1:0] word,
  output logic                        found,
  output logic [FANOUT_LOG2-1:0]      idx
);

  localparam int FAN = 1 << FANOUT_LOG2;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = FAN - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        idx   = FANOUT_LOG2'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/hierarchical_bitmap_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// hierarchical_bitmap_slot_allocator_top: four-level bitmap slot allocator
// Allocates the lowest free slot near the cursor leaf word, climbing and
// descending the full-mark tree as needed, and frees slots on request.
// ----------------------------------------------------------------------------
//  Channel   Ports                                      Direction
//  input     in_valid, in_stall, in_action, in_slot_index   in
//  result    out_valid, out_stall, out_granted_slot, out_status out
//
// After reset a clearing pass over every memory word accepts no transaction.
// A free reads the tree words and clears its marks at each level; an allocate
// that hits the cursor word sets its lowest clear bit. A retry climbs one, two
// or three levels and descends to a new cursor word, through the single
// lowest-clear-bit unit and the registered memory reads; a full root gives OOM.
// A stalled result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_slot_allocator_top #(
  parameter int FANOUT_LOG2 = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_granted_slot,
  output logic        out_status
);

  localparam int FL  = FANOUT_LOG2;
  localparam int FAN = 1 << FL;
  localparam int LW  = 3 * FL;
  localparam int SW  = 4 * FL;
  localparam int CAP = (1 << (3 * FL)) + (1 << (2 * FL)) + (1 << FL) + 4;
  localparam int TW  = $clog2(CAP + 1);

  hbsa_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]   cursor_r, cursor_nxt;
  logic [FAN-1:0]  root_r, root_nxt;
  logic [TW-1:0]   tries_r, tries_nxt;
  logic            op_r, op_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [2*FL-1:0] c3_r, c3_nxt;
  logic [15:0]     res_slot_r, res_slot_nxt;
  logic            res_st_r, res_st_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     out_slot_r, out_slot_nxt;
  logic            out_st_r, out_st_nxt;

  logic            leaf_we, l3_we, l2_we, leaf_re, l3_re, l2_re;
  logic [LW-1:0]   leaf_wa, leaf_ra;
  logic [2*FL-1:0] l3_wa, l3_ra;
  logic [FL-1:0]   l2_wa, l2_ra;
  logic [FAN-1:0]  leaf_wd, l3_wd, l2_wd, leaf_rd, l3_rd, l2_rd;

  logic [FAN-1:0]  fword;
  logic            ffound;
  logic [FL-1:0]   fidx, fpick;

  logic [LW-1:0]   lw;
  logic [2*FL-1:0] w3;
  logic [FL-1:0]   w2;
  logic [FAN-1:0]  n3, n2, nr;

  hbsa_ram #(.WIDTH(FAN), .DEPTH(1 << LW)) u_leaf (
    .clk(clk), .we(leaf_we), .waddr(leaf_wa), .wdata(leaf_wd),
    .re(leaf_re), .raddr(leaf_ra), .rdata(leaf_rd)
  );

  hbsa_ram #(.WIDTH(FAN), .DEPTH(1 << (2 * FL))) u_l3 (
    .clk(clk), .we(l3_we), .waddr(l3_wa), .wdata(l3_wd),
    .re(l3_re), .raddr(l3_ra), .rdata(l3_rd)
  );

  hbsa_ram #(.WIDTH(FAN), .DEPTH(1 << FL)) u_l2 (
    .clk(clk), .we(l2_we), .waddr(l2_wa), .wdata(l2_wd),
    .re(l2_re), .raddr(l2_ra), .rdata(l2_rd)
  );

  hbsa_find #(.FANOUT_LOG2(FL)) u_find (
    .word(fword), .found(ffound), .idx(fidx)
  );

  assign fpick = ffound ? fidx : '0;

  assign lw = (op_r == hbsa_pkg::ACT_FREE) ? slot_r[SW-1:FL] : cursor_r;
  assign w3 = lw[LW-1:FL];
  assign w2 = lw[LW-1:2*FL];
  assign n3 = l3_rd | (FAN'(1) << lw[FL-1:0]);
  assign n2 = l2_rd | (FAN'(1) << w3[FL-1:0]);
  assign nr = root_r | (FAN'(1) << w2);

  assign in_stall         = (state_r != hbsa_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hbsa_pkg::S_CLR;
      cnt_r       <= '0;
      cursor_r    <= '0;
      root_r      <= '0;
      tries_r     <= '0;
      op_r        <= hbsa_pkg::ACT_ALLOC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cursor_r    <= cursor_nxt;
      root_r      <= root_nxt;
      tries_r     <= tries_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    c3_r       <= c3_nxt;
    res_slot_r <= res_slot_nxt;
    res_st_r   <= res_st_nxt;
    out_slot_r <= out_slot_nxt;
    out_st_r   <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cursor_nxt    = cursor_r;
    root_nxt      = root_r;
    tries_nxt     = tries_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    c3_nxt        = c3_r;
    res_slot_nxt  = res_slot_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_st_nxt    = out_st_r;

    leaf_we = 1'b0; leaf_wa = lw;                leaf_wd = '0;
    l3_we   = 1'b0; l3_wa   = w3;                l3_wd   = '0;
    l2_we   = 1'b0; l2_wa   = w2;                l2_wd   = '0;
    leaf_re = 1'b0; leaf_ra = lw;
    l3_re   = 1'b0; l3_ra   = w3;
    l2_re   = 1'b0; l2_ra   = w2;
    fword   = leaf_rd;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      hbsa_pkg::S_CLR: begin
        leaf_we = 1'b1; leaf_wa = cnt_r;
        l3_we   = 1'b1; l3_wa   = cnt_r[2*FL-1:0];
        l2_we   = 1'b1; l2_wa   = cnt_r[FL-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = hbsa_pkg::S_IDLE;
        end
      end
      hbsa_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_action;
          slot_nxt  = SW'(in_slot_index);
          tries_nxt = '0;
          state_nxt = hbsa_pkg::S_RD;
        end
      end
      hbsa_pkg::S_RD: begin
        leaf_re = 1'b1;
        l3_re   = 1'b1;
        l2_re   = 1'b1;
        state_nxt = (op_r == hbsa_pkg::ACT_FREE) ? hbsa_pkg::S_FW : hbsa_pkg::S_EVAL;
      end
      hbsa_pkg::S_FW: begin
        leaf_we = 1'b1; leaf_wd = leaf_rd & ~(FAN'(1) << slot_r[FL-1:0]);
        l3_we   = 1'b1; l3_wd   = l3_rd & ~(FAN'(1) << lw[FL-1:0]);
        l2_we   = 1'b1; l2_wd   = l2_rd & ~(FAN'(1) << w3[FL-1:0]);
        root_nxt     = root_r & ~(FAN'(1) << w2);
        res_slot_nxt = '0;
        res_st_nxt   = hbsa_pkg::ST_OK;
        state_nxt    = hbsa_pkg::S_OUT;
      end
      hbsa_pkg::S_EVAL: begin
        fword = leaf_rd;
        if (ffound) begin
          leaf_we      = 1'b1;
          leaf_wd      = leaf_rd | (FAN'(1) << fidx);
          res_slot_nxt = 16'({lw, fidx});
          res_st_nxt   = hbsa_pkg::ST_OK;
          state_nxt    = hbsa_pkg::S_OUT;
        end else begin
          state_nxt = hbsa_pkg::S_M3;
        end
      end
      hbsa_pkg::S_M3: begin
        fword = n3;
        l3_we = 1'b1;
        l3_wd = n3;
        if (n3 != '1) begin
          cursor_nxt = {w3, fpick};
          if (tries_r == TW'(CAP - 1)) begin
            res_slot_nxt = '0;
            res_st_nxt   = hbsa_pkg::ST_OOM;
            state_nxt    = hbsa_pkg::S_OUT;
          end else begin
            tries_nxt = tries_r + 1'b1;
            state_nxt = hbsa_pkg::S_RD;
          end
        end else begin
          state_nxt = hbsa_pkg::S_M2;
        end
      end
      hbsa_pkg::S_M2: begin
        fword = n2;
        l2_we = 1'b1;
        l2_wd = n2;
        if (n2 != '1) begin
          c3_nxt    = {w2, fpick};
          l3_re     = 1'b1;
          l3_ra     = {w2, fpick};
          state_nxt = hbsa_pkg::S_PK3;
        end else begin
          state_nxt = hbsa_pkg::S_MR;
        end
      end
      hbsa_pkg::S_MR: begin
        fword    = nr;
        root_nxt = nr;
        if (nr == '1) begin
          res_slot_nxt = '0;
          res_st_nxt   = hbsa_pkg::ST_OOM;
          state_nxt    = hbsa_pkg::S_OUT;
        end else begin
          c3_nxt    = {fpick, {FL{1'b0}}};
          l2_re     = 1'b1;
          l2_ra     = fpick;
          state_nxt = hbsa_pkg::S_PK2;
        end
      end
      hbsa_pkg::S_PK2: begin
        fword     = l2_rd;
        c3_nxt    = {c3_r[2*FL-1:FL], fpick};
        l3_re     = 1'b1;
        l3_ra     = {c3_r[2*FL-1:FL], fpick};
        state_nxt = hbsa_pkg::S_PK3;
      end
      hbsa_pkg::S_PK3: begin
        fword      = l3_rd;
        cursor_nxt = {c3_r, fpick};
        if (tries_r == TW'(CAP - 1)) begin
          res_slot_nxt = '0;
          res_st_nxt   = hbsa_pkg::ST_OOM;
          state_nxt    = hbsa_pkg::S_OUT;
        end else begin
          tries_nxt = tries_r + 1'b1;
          state_nxt = hbsa_pkg::S_RD;
        end
      end
      hbsa_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = res_slot_r;
          out_st_nxt    = res_st_r;
          state_nxt     = hbsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hbsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sim/tb_hierarchical_bitmap_slot_allocator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hierarchical_bitmap_slot_allocator_top: allocator self-checking bench
// Drives allocate and free transactions under random sender and receiver
// idling, keeps its own copy of the four-level bitmap tree to predict every
// granted slot and status, and mixes frees and allocates over the whole
// slot space.
// ----------------------------------------------------------------------------
module tb_hierarchical_bitmap_slot_allocator_top;

  localparam int RETRY_LIMIT = 4096 + 256 + 16 + 4;

  typedef struct packed {
    logic        action;
    logic [15:0] slot_index;
  } request_t;

  typedef struct packed {
    logic [15:0] granted_slot;
    logic        status;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [15:0] in_slot_index;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_granted_slot;
  logic        out_status;

  request_t    request_q[$];
  grant_t      grant_q[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          in_taken;
  int          errors;

  logic [15:0] used_bits[4096];
  logic [15:0] l3_full[256];
  logic [15:0] l2_full[16];
  logic [15:0] root_full;
  logic [11:0] cursor;

  hierarchical_bitmap_slot_allocator_top uut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [4:0] lowest_clear(logic [15:0] w);
    for (int i = 0; i < 16; i++) begin
      if (!w[i]) return 5'(i);
    end
    return 5'd16;
  endfunction

  function automatic logic [3:0] pick_child(logic [15:0] w);
    logic [4:0] b;
    b = lowest_clear(w);
    return (b == 5'd16) ? 4'd0 : b[3:0];
  endfunction

  task automatic predict_alloc(output grant_t g);
    logic [11:0] lw;
    logic [7:0]  w3;
    logic [7:0]  c3;
    logic [3:0]  w2;
    logic [3:0]  c;
    logic [4:0]  b;
    for (int tries = 0; tries < RETRY_LIMIT; tries++) begin
      lw = cursor;
      w3 = lw[11:4];
      w2 = lw[11:8];
      b = lowest_clear(used_bits[lw]);
      if (b != 5'd16) begin
        used_bits[lw][b[3:0]] = 1'b1;
        g = '{{lw, b[3:0]}, hbsa_pkg::ST_OK};
        return;
      end
      l3_full[w3][lw[3:0]] = 1'b1;
      if (l3_full[w3] != 16'hFFFF) begin
        cursor = {w3, pick_child(l3_full[w3])};
        continue;
      end
      l2_full[w2][w3[3:0]] = 1'b1;
      if (l2_full[w2] != 16'hFFFF) begin
        c3 = {w2, pick_child(l2_full[w2])};
        cursor = {c3, pick_child(l3_full[c3])};
        continue;
      end
      root_full[w2] = 1'b1;
      if (root_full == 16'hFFFF) begin
        g = '{16'd0, hbsa_pkg::ST_OOM};
        return;
      end
      c = pick_child(root_full);
      c3 = {c, pick_child(l2_full[c])};
      cursor = {c3, pick_child(l3_full[c3])};
    end
    g = '{16'd0, hbsa_pkg::ST_OOM};
  endtask

  task automatic predict_free(logic [15:0] s);
    used_bits[s[15:4]][s[3:0]] = 1'b0;
    l3_full[s[15:8]][s[7:4]] = 1'b0;
    l2_full[s[15:12]][s[11:8]] = 1'b0;
    root_full[s[15:12]] = 1'b0;
  endtask

  always @(posedge clk) begin
    grant_t g;
    grant_t want;
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      if (in_action == hbsa_pkg::ACT_ALLOC) begin
        predict_alloc(g);
      end else begin
        predict_free(in_slot_index);
        g = '{16'd0, hbsa_pkg::ST_OK};
      end
      grant_q.push_back(g);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result slot %0d status %0d", $time,
                 out_granted_slot, out_status);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (out_granted_slot !== want.granted_slot) begin
          $display("%0t: granted_slot expected %0d actual %0d", $time,
                   want.granted_slot, out_granted_slot);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    request_t r;
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = request_q.pop_front();
        in_action <= r.action;
        in_slot_index <= r.slot_index;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic queue_random(int count, int span);
    request_t r;
    for (int i = 0; i < count; i++) begin
      r.action = ($urandom_range(99) < 60) ? hbsa_pkg::ACT_ALLOC : hbsa_pkg::ACT_FREE;
      if ($urandom_range(3) == 0) begin
        r.slot_index = 16'($urandom);
      end else begin
        r.slot_index = 16'($urandom_range(span));
      end
      request_q.push_back(r);
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || grant_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = hbsa_pkg::ACT_ALLOC;
    in_slot_index = '0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    errors = 0;
    send_idle_pct = 21;
    recv_idle_pct = 52;
    foreach (used_bits[i]) used_bits[i] = '0;
    foreach (l3_full[i]) l3_full[i] = '0;
    foreach (l2_full[i]) l2_full[i] = '0;
    root_full = '0;
    cursor = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 18; i++) request_q.push_back('{hbsa_pkg::ACT_ALLOC, 16'd0});
    request_q.push_back('{hbsa_pkg::ACT_FREE, 16'd0});
    request_q.push_back('{hbsa_pkg::ACT_FREE, 16'd0});
    request_q.push_back('{hbsa_pkg::ACT_FREE, 16'hFFFF});
    request_q.push_back('{hbsa_pkg::ACT_FREE, 16'h8000});
    request_q.push_back('{hbsa_pkg::ACT_FREE, 16'd5});
    request_q.push_back('{hbsa_pkg::ACT_ALLOC, 16'hFFFF});
    request_q.push_back('{hbsa_pkg::ACT_ALLOC, 16'h5555});
    queue_random(700, 120);
    wait_drained();

    send_idle_pct = 52;
    recv_idle_pct = 21;
    queue_random(700, 400);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(40, 65535);
    for (int i = 0; i < 20; i++) begin
      request_q.push_back('{hbsa_pkg::ACT_FREE, 16'($urandom)});
      request_q.push_back('{hbsa_pkg::ACT_ALLOC, 16'($urandom)});
    end
    wait_drained();

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hbsa_pkg.sv
hw/rtl/hbsa_ram.sv
hw/rtl/hbsa_find.sv
hw/rtl/hierarchical_bitmap_slot_allocator_top.sv
sim/tb_hierarchical_bitmap_slot_allocator_top.sv
